// ----- design/tdsp_pkg.sv -----
// Shared constants, register codes and pipeline control types for the stick-to-PWM block.
`default_nettype none

package tdsp_pkg;

  localparam int AXIS_W   = 8;
  localparam int DRIVE_W  = 15;
  localparam int LIMIT_W  = 14;
  localparam int COUNT_W  = 7;
  localparam int STEP_W   = 10;
  localparam int CEIL_W   = 13;
  localparam int BAND_W   = 12;
  localparam int CFG_W    = 13;
  localparam int MAG_W    = 8;
  localparam int PROD_W   = MAG_W + LIMIT_W;
  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 30;
  localparam int FULL_W   = PROD_W + RECIP_W;

  // ceil(2^30 / 255); exact floor division for products below about 5.6 million.
  localparam logic [RECIP_W-1:0] RECIP_255 = 23'd4210753;

  localparam logic [STEP_W-1:0] STEP_RESET = 10'd500;
  localparam logic [CEIL_W-1:0] CEIL_RESET = 13'd4000;
  localparam logic [BAND_W-1:0] BAND_RESET = 12'd250;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  typedef enum logic [1:0] {
    REG_SPEED_STEP    = 2'd0,
    REG_SPEED_CEILING = 2'd1,
    REG_DEAD_BAND     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load_b;
    logic load_c;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- design/tdsp_speed.sv -----
// Button edge detection and the kept speed limit and step count.
`default_nettype none

module tdsp_speed (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           take,
  input  wire                           up_pressed,
  input  wire                           down_pressed,
  input  wire [tdsp_pkg::STEP_W-1:0]    speed_step,
  input  wire [tdsp_pkg::CEIL_W-1:0]    speed_ceiling,
  output logic [tdsp_pkg::LIMIT_W-1:0]  limit,
  output logic [tdsp_pkg::COUNT_W-1:0]  count
);
  import tdsp_pkg::*;

  logic                up_latch;
  logic                down_latch;
  logic [LIMIT_W-1:0]  lim_mid;
  logic [COUNT_W-1:0]  cnt_mid;
  logic [LIMIT_W-1:0]  limit_next;
  logic [COUNT_W-1:0]  count_next;
  logic [LIMIT_W-1:0]  step_ext;

  assign step_ext = LIMIT_W'(speed_step);

  always_comb begin
    lim_mid    = limit;
    cnt_mid    = count;
    limit_next = limit;
    count_next = count;
    // The up press is applied first; the down press sees its result.
    if (up_pressed && !up_latch && (limit < LIMIT_W'(speed_ceiling))) begin
      lim_mid = limit + step_ext;
      if (count != COUNT_MAX) begin
        cnt_mid = count + 1'b1;
      end
    end
    limit_next = lim_mid;
    count_next = cnt_mid;
    if (down_pressed && !down_latch && (lim_mid != '0)) begin
      limit_next = (lim_mid > step_ext) ? (lim_mid - step_ext) : '0;
      if (cnt_mid != '0) begin
        count_next = cnt_mid - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_latch   <= 1'b0;
      down_latch <= 1'b0;
      limit      <= '0;
      count      <= '0;
    end else if (take) begin
      // A latch simply follows its button: release clears it, a press sets it.
      up_latch   <= up_pressed;
      down_latch <= down_pressed;
      limit      <= limit_next;
      count      <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/tdsp_axis.sv -----
// One stick axis: scale by the speed limit, divide by 255, apply the dead band.
`default_nettype none

module tdsp_axis (
  input  wire                                 clk,
  input  wire                                 rst,
  input  tdsp_pkg::pipe_ctl_t                 ctl,
  input  wire [tdsp_pkg::AXIS_W-1:0]          axis,
  input  wire [tdsp_pkg::LIMIT_W-1:0]         limit,
  input  wire [tdsp_pkg::BAND_W-1:0]          dead_band,
  output logic signed [tdsp_pkg::DRIVE_W-1:0] drive_next,
  output logic signed [tdsp_pkg::DRIVE_W-1:0] drive
);
  import tdsp_pkg::*;

  logic [MAG_W:0]      twice;
  logic [MAG_W-1:0]    span;
  logic [PROD_W-1:0]   prod_b;
  logic                neg_b;
  logic [FULL_W-1:0]   full;
  logic [LIMIT_W-1:0]  quot;
  logic [LIMIT_W-1:0]  mag;
  logic [DRIVE_W-1:0]  mag_ext;

  // Distance of 2*axis from 255; always odd, so never zero.
  assign twice = {axis, 1'b0};
  assign span  = axis[AXIS_W-1] ? MAG_W'(twice - 9'd255) : MAG_W'(9'd255 - twice);

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      prod_b <= span * limit;
      neg_b  <= axis[AXIS_W-1];
    end
  end

  assign full    = FULL_W'(prod_b) * FULL_W'(RECIP_255);
  assign quot    = full[RECIP_SH +: LIMIT_W];
  assign mag     = (quot < LIMIT_W'(dead_band)) ? '0 : quot;
  assign mag_ext = DRIVE_W'(mag);

  always_comb begin
    drive_next = neg_b ? $signed(~mag_ext + 1'b1) : $signed(mag_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
    end else if (ctl.load_c) begin
      drive <= drive_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/tank_drive_stick_to_pwm.sv -----
// Top level of the gamepad stick to tank-drive PWM converter.
`default_nettype none

// Each transaction carries one gamepad sample and yields exactly one result; a new sample can
// be taken every cycle while in_stall is low. The three pipeline stages are the speed-limit
// update, the axis-times-limit product, and the divide by 255 (a reciprocal multiply) with
// dead band and change detection. in_stall follows out_stall through the stage occupancy,
// so a held result does not block new samples until the pipeline is full. After reset the
// step is 500, the ceiling 4000, the dead band 250 and the speed limit zero, so both drives
// read zero until the first up press.
module tank_drive_stick_to_pwm (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire [1:0]                           cfg_index,
  input  wire [tdsp_pkg::CFG_W-1:0]           cfg_data,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 up_pressed,
  input  wire                                 down_pressed,
  input  wire [tdsp_pkg::AXIS_W-1:0]          left_axis,
  input  wire [tdsp_pkg::AXIS_W-1:0]          right_axis,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [tdsp_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [tdsp_pkg::DRIVE_W-1:0] right_drive,
  output logic                                drive_changed,
  output logic [tdsp_pkg::COUNT_W-1:0]        speed_level
);
  import tdsp_pkg::*;

  logic [STEP_W-1:0]          speed_step;
  logic [CEIL_W-1:0]          speed_ceiling;
  logic [BAND_W-1:0]          dead_band;

  logic                       va;
  logic                       vb;
  logic                       ready_a;
  logic                       ready_b;
  logic                       ready_c;
  logic                       in_acc;
  pipe_ctl_t                  ctl;

  logic [AXIS_W-1:0]          left_a;
  logic [AXIS_W-1:0]          right_a;
  logic [LIMIT_W-1:0]         speed_limit;
  logic [COUNT_W-1:0]         count_a;
  logic [COUNT_W-1:0]         count_b;
  logic signed [DRIVE_W-1:0]  left_next;
  logic signed [DRIVE_W-1:0]  right_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_step    <= STEP_RESET;
      speed_ceiling <= CEIL_RESET;
      dead_band     <= BAND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SPEED_STEP:    speed_step    <= cfg_data[STEP_W-1:0];
        REG_SPEED_CEILING: speed_ceiling <= cfg_data[CEIL_W-1:0];
        REG_DEAD_BAND:     dead_band     <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage moves on when the stage after it is empty or moving on too.
  assign ready_c    = !out_valid || !out_stall;
  assign ready_b    = !vb || ready_c;
  assign ready_a    = !va || ready_b;
  assign ctl.load_c = vb && ready_c;
  assign ctl.load_b = va && ready_b;
  assign in_stall   = !ready_a;
  assign in_acc     = in_valid && ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_acc || (va && !ctl.load_b);
      vb        <= ctl.load_b || (vb && !ctl.load_c);
      out_valid <= ctl.load_c || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_a  <= left_axis;
      right_a <= right_axis;
    end
    if (ctl.load_b) begin
      count_b <= count_a;
    end
    if (ctl.load_c) begin
      speed_level <= count_b;
      // The drive registers still hold the previous transaction's drives.
      drive_changed <= (left_next != left_drive) || (right_next != right_drive);
    end
  end

  tdsp_speed u_speed (
    .clk           (clk),
    .rst           (rst),
    .take          (in_acc),
    .up_pressed    (up_pressed),
    .down_pressed  (down_pressed),
    .speed_step    (speed_step),
    .speed_ceiling (speed_ceiling),
    .limit         (speed_limit),
    .count         (count_a)
  );

  tdsp_axis u_left (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .axis       (left_a),
    .limit      (speed_limit),
    .dead_band  (dead_band),
    .drive_next (left_next),
    .drive      (left_drive)
  );

  tdsp_axis u_right (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .axis       (right_a),
    .limit      (speed_limit),
    .dead_band  (dead_band),
    .drive_next (right_next),
    .drive      (right_drive)
  );

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (va && vb && out_valid && out_stall) |-> in_stall)
    else $error("pipeline full and stalled but input not stalled");

  a_limit_held: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(speed_limit))
    else $error("speed limit moved without an accepted transaction");

  a_drive_held: assert property (@(posedge clk) disable iff (rst)
    !ctl.load_c |=> ($stable(left_drive) && $stable(right_drive)))
    else $error("drive registers changed without a result load");

endmodule

`default_nettype wire

// ----- tb/tank_drive_stick_to_pwm_tb.sv -----
// Self-checking testbench for the tank-drive stick to PWM converter.
module tank_drive_stick_to_pwm_tb;
  import tdsp_pkg::*;

  typedef struct {
    logic [DRIVE_W-1:0] left;
    logic [DRIVE_W-1:0] right;
    logic               changed;
    logic [COUNT_W-1:0] level;
  } drive_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = 2'd0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                up_pressed = 1'b0;
  logic                down_pressed = 1'b0;
  logic [AXIS_W-1:0]   left_axis = '0;
  logic [AXIS_W-1:0]   right_axis = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DRIVE_W-1:0]  left_drive;
  logic [DRIVE_W-1:0]  right_drive;
  logic                drive_changed;
  logic [COUNT_W-1:0]  speed_level;

  // Predictor state and its copy of the registers.
  logic                up_held = 1'b0;
  logic                down_held = 1'b0;
  logic [LIMIT_W-1:0]  limit_q = '0;
  logic [COUNT_W-1:0]  steps_q = '0;
  logic [DRIVE_W-1:0]  last_left = '0;
  logic [DRIVE_W-1:0]  last_right = '0;
  logic [STEP_W-1:0]   step_cfg = STEP_RESET;
  logic [CEIL_W-1:0]   ceil_cfg = CEIL_RESET;
  logic [BAND_W-1:0]   band_cfg = BAND_RESET;

  drive_result_t       pending_drives[$];
  int                  failures = 0;
  logic                tx_idle = 1'b0;
  logic                rx_idle = 1'b0;
  logic                long_hold = 1'b0;

  tank_drive_stick_to_pwm i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .up_pressed    (up_pressed),
    .down_pressed  (down_pressed),
    .left_axis     (left_axis),
    .right_axis    (right_axis),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .drive_changed (drive_changed),
    .speed_level   (speed_level)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 300000);
    $display("FAIL tank_drive_stick_to_pwm");
    $finish;
  end

  // Signed drive for one axis: truncated toward zero, then the dead band.
  function automatic logic [DRIVE_W-1:0] axis_to_drive(logic [AXIS_W-1:0] axis);
    int num;
    int mag;
    num = (255 - 2 * int'(axis)) * int'(limit_q);
    mag = (num < 0 ? -num : num) / 255;
    if (mag < int'(band_cfg)) mag = 0;
    return DRIVE_W'(num < 0 ? -mag : mag);
  endfunction

  function automatic drive_result_t predict_drive(logic up, logic down,
                                                 logic [AXIS_W-1:0] l_axis,
                                                 logic [AXIS_W-1:0] r_axis);
    drive_result_t res;
    if (!up) up_held = 1'b0;
    if (!down) down_held = 1'b0;
    // The up edge is applied before the down edge of the same sample.
    if (up && !up_held) begin
      up_held = 1'b1;
      if (limit_q < ceil_cfg) begin
        limit_q = limit_q + step_cfg;
        if (steps_q != COUNT_MAX) steps_q = steps_q + 1'b1;
      end
    end
    if (down && !down_held) begin
      down_held = 1'b1;
      if (limit_q != '0) begin
        limit_q = (limit_q > step_cfg) ? limit_q - step_cfg : '0;
        if (steps_q != '0) steps_q = steps_q - 1'b1;
      end
    end
    res.left = axis_to_drive(l_axis);
    res.right = axis_to_drive(r_axis);
    res.changed = (res.left != last_left) || (res.right != last_right);
    res.level = steps_q;
    last_left = res.left;
    last_right = res.right;
    return res;
  endfunction

  function automatic logic [AXIS_W-1:0] random_axis();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127;
      3: return 8'd128;
      default: return AXIS_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic random_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic send_sample(logic up, logic down, logic [AXIS_W-1:0] l_axis,
                             logic [AXIS_W-1:0] r_axis);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    up_pressed <= up;
    down_pressed <= down;
    left_axis <= l_axis;
    right_axis <= r_axis;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_drives.push_back(predict_drive(up, down, l_axis, r_axis));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(int step, int ceiling, int band);
    cfg_write <= 1'b1;
    cfg_index <= REG_SPEED_STEP;
    cfg_data <= CFG_W'(step);
    @(posedge clk);
    cfg_index <= REG_SPEED_CEILING;
    cfg_data <= CFG_W'(ceiling);
    @(posedge clk);
    cfg_index <= REG_DEAD_BAND;
    cfg_data <= CFG_W'(band);
    @(posedge clk);
    cfg_write <= 1'b0;
    step_cfg = STEP_W'(step);
    ceil_cfg = CEIL_W'(ceiling);
    band_cfg = BAND_W'(band);
  endtask

  task automatic hold_receiver(int cycles);
    fork
      begin
        long_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
  endtask

  // Receiver pacing: after each accepted result, draw the wait before the next one.
  always @(posedge clk) begin : rx_pacing
    int unsigned wait_left;
    int unsigned n;
    if (rst) begin
      out_stall <= 1'b0;
      wait_left = 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (wait_left != 0) begin
      out_stall <= 1'b1;
      wait_left = wait_left - 1;
    end else if (out_valid && !out_stall) begin
      n = rx_idle ? $urandom_range(0, 4) : 0;
      out_stall <= (n != 0);
      wait_left = (n != 0) ? n - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_drives
    drive_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        note_failure("Unexpected result transaction with no sample pending");
      end else begin
        want = pending_drives.pop_front();
        if (left_drive !== want.left || right_drive !== want.right ||
            drive_changed !== want.changed || speed_level !== want.level) begin
          note_failure($sformatf(
            "Mismatch: expected L=%0d R=%0d chg=%0b lvl=%0d, got L=%0d R=%0d chg=%0b lvl=%0d",
            $signed(want.left), $signed(want.right), want.changed, want.level,
            $signed(left_drive), $signed(right_drive), drive_changed, speed_level));
        end
      end
    end
  end

  // Reset values, button edges, holds, simultaneous presses and the floor at zero.
  task automatic test_reset_state_and_buttons();
    send_sample(1'b0, 1'b0, 8'd0, 8'd255);
    send_sample(1'b1, 1'b0, 8'd0, 8'd255);
    send_sample(1'b1, 1'b0, 8'd0, 8'd255);
    send_sample(1'b0, 1'b0, 8'd127, 8'd128);
    send_sample(1'b1, 1'b1, 8'd64, 8'd191);
    send_sample(1'b0, 1'b1, 8'd64, 8'd191);
    send_sample(1'b0, 1'b0, 8'd255, 8'd0);
    send_sample(1'b0, 1'b1, 8'd255, 8'd0);
    send_sample(1'b0, 1'b0, 8'd200, 8'd10);
    send_sample(1'b0, 1'b1, 8'd200, 8'd10);
    send_sample(1'b1, 1'b0, 8'd0, 8'd0);
    wait_idle();
  endtask

  // Zero step, widest step and ceiling, largest dead band, and a ceiling of zero.
  task automatic test_register_extremes();
    set_config(0, 8191, 0);
    send_sample(1'b0, 1'b0, 8'd127, 8'd128);
    send_sample(1'b1, 1'b0, 8'd127, 8'd0);
    send_sample(1'b0, 1'b0, 8'd255, 8'd128);
    send_sample(1'b1, 1'b0, 8'd1, 8'd254);
    wait_idle();
    set_config(1023, 8191, 4095);
    for (int i = 0; i < 8; i++) send_sample(i[0], 1'b0, 8'd0, 8'd255);
    wait_idle();
    set_config(1023, 0, 0);
    send_sample(1'b1, 1'b0, 8'd0, 8'd128);
    send_sample(1'b0, 1'b1, 8'd0, 8'd128);
    send_sample(1'b1, 1'b0, 8'd0, 8'd255);
    send_sample(1'b0, 1'b1, 8'd127, 8'd255);
    wait_idle();
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 3; k++) begin
      set_config($urandom_range(100, 1000), $urandom_range(0, 8191), $urandom_range(0, 600));
      tx_idle = k[0];
      rx_idle = (k != 2);
      for (int i = 0; i < 10; i++)
        send_sample(random_bit(), random_bit(), random_axis(), random_axis());
      wait_idle();
    end
    set_config(1023, 8191, 0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < 20; i++)
      send_sample(random_bit(), $urandom_range(0, 3) == 0, random_axis(), random_axis());
    wait_idle();
    set_config($urandom_range(0, 1023), $urandom_range(0, 8191), $urandom_range(0, 4095));
    for (int i = 0; i < 10; i++)
      send_sample(random_bit(), random_bit(), random_axis(), random_axis());
    wait_idle();
  endtask

  // The receiver stops long enough for the pipeline to fill and stall its input.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_receiver(40);
    for (int i = 0; i < 24; i++)
      send_sample(random_bit(), random_bit(), random_axis(), random_axis());
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < 16; i++)
      send_sample(random_bit(), random_bit(), random_axis(), random_axis());
    wait_idle();
  endtask

  // Drain the limit to zero, then count up edges with a zero step until the level saturates.
  task automatic test_count_saturation();
    set_config(1023, 8191, 100);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 24; i++) send_sample(1'b0, i[0], random_axis(), random_axis());
    wait_idle();
    set_config(0, 8191, 100);
    for (int i = 0; i < 260; i++) send_sample(i[0], 1'b0, random_axis(), random_axis());
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < 10; i++)
      send_sample(random_bit(), random_bit(), random_axis(), random_axis());
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state_and_buttons();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    test_count_saturation();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("PASS tank_drive_stick_to_pwm");
    end else begin
      $display("FAIL tank_drive_stick_to_pwm");
    end
    $finish;
  end

endmodule
